@@ rtl/core/pwlcs_pkg.sv @@
// types, constants and divider step function for the contrast stretch block
package pwlcs_pkg;

    localparam int PIX_W           = 8;
    localparam int NUM_W           = 2 * PIX_W;
    localparam int CFG_IDX_W       = 8;
    localparam int DIV_STAGES      = 4;
    localparam int QBITS_PER_STAGE = PIX_W / DIV_STAGES;

    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [NUM_W-1:0]     num_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t REG_IN_KNEE_LOW   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_OUT_KNEE_LOW  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_IN_KNEE_HIGH  = cfg_idx_t'(2);
    localparam cfg_idx_t REG_OUT_KNEE_HIGH = cfg_idx_t'(3);

    localparam pix_t LEVEL_MAX             = pix_t'(255);
    localparam pix_t RST_IN_KNEE_LOW       = pix_t'(90);
    localparam pix_t RST_OUT_KNEE_LOW      = pix_t'(10);
    localparam pix_t RST_IN_KNEE_HIGH      = pix_t'(120);
    localparam pix_t RST_OUT_KNEE_HIGH     = pix_t'(150);

    // per-item control that rides along the pipeline
    typedef struct packed {
        pix_t pix;
        logic bypass;
        logic neg;
        pix_t base;
        pix_t den;
    } ctl_t;

    // partial division state
    typedef struct packed {
        ctl_t ctl;
        pix_t rem;
        pix_t low;
        pix_t quo;
    } div_t;

    // one restoring-division stage, several quotient bits
    function automatic div_t div_stage(div_t d);
        div_t             r;
        logic [PIX_W:0]   rem_ext;
        r = d;
        for (int j = 0; j < QBITS_PER_STAGE; j++)
        begin
            rem_ext = {r.rem, r.low[PIX_W-1]};
            r.low   = {r.low[PIX_W-2:0], 1'b0};
            if (rem_ext >= {1'b0, r.ctl.den})
            begin
                rem_ext = rem_ext - {1'b0, r.ctl.den};
                r.quo   = {r.quo[PIX_W-2:0], 1'b1};
            end
            else
            begin
                r.quo   = {r.quo[PIX_W-2:0], 1'b0};
            end
            r.rem = rem_ext[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/piecewise_linear_contrast_stretch.sv @@
// piecewise linear contrast stretch, top level
//
// Maps one 8-bit gray pixel per clock through a three-segment transfer curve
// through (0,0), (in_knee_low,out_knee_low), (in_knee_high,out_knee_high) and
// (255,255); each segment value is the exact floor of its rational form. If
// in_knee_low equals in_knee_high, in_knee_low is 0 or in_knee_high is 255 the
// pixel passes unchanged. Throughput is one item per clock while dst_stall is
// low. Each item passes through seven register stages in order: one stage
// picks the segment, one multiplies, four stages run the restoring divider
// two quotient bits each, and one applies the segment offset. Stalls collapse
// bubbles stage by stage, so src_stall only rises when every stage is full
// and dst_stall is high. Configuration writes are always accepted
// (cfg_ready is tied high), indexes above 3 are ignored, and registers
// should be written only while no item is in flight.
module piecewise_linear_contrast_stretch
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  pwlcs_pkg::cfg_idx_t        cfg_index,
    input  pwlcs_pkg::pix_t            cfg_data,
    // pixel input channel
    input  logic                       src_valid,
    output logic                       src_stall,
    input  pwlcs_pkg::pix_t            pixel_in,
    // pixel output channel
    output logic                       dst_valid,
    input  logic                       dst_stall,
    output pwlcs_pkg::pix_t            pixel_out
);
    import pwlcs_pkg::*;

    // stage 0 select, stage 1 multiply, stages 2..DIV_STAGES+1 divider, last stage result
    localparam int NS = DIV_STAGES + 3;

    pix_t in_knee_low_reg;
    pix_t out_knee_low_reg;
    pix_t in_knee_high_reg;
    pix_t out_knee_high_reg;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] adv;

    ctl_t sel_ctl_next;
    pix_t sel_a_next;
    pix_t sel_b_next;
    ctl_t sel_ctl_reg;
    pix_t sel_a_reg;
    pix_t sel_b_reg;

    num_t prod;
    div_t div_init;
    div_t div_reg [0:DIV_STAGES];
    pix_t result_next;
    pix_t result_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_knee_low_reg   <= RST_IN_KNEE_LOW;
            out_knee_low_reg  <= RST_OUT_KNEE_LOW;
            in_knee_high_reg  <= RST_IN_KNEE_HIGH;
            out_knee_high_reg <= RST_OUT_KNEE_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IN_KNEE_LOW:   in_knee_low_reg   <= cfg_data;
                REG_OUT_KNEE_LOW:  out_knee_low_reg  <= cfg_data;
                REG_IN_KNEE_HIGH:  in_knee_high_reg  <= cfg_data;
                REG_OUT_KNEE_HIGH: out_knee_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the stage after it moves
    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || !dst_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign src_stall = !adv[0];
    assign dst_valid = valid_reg[NS-1];
    assign pixel_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= src_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // segment select: multiplier operands, divisor and offset per segment
    always_comb
    begin
        sel_ctl_next.pix    = pixel_in;
        sel_ctl_next.bypass = (in_knee_low_reg == in_knee_high_reg)
                              || (in_knee_low_reg == '0)
                              || (in_knee_high_reg == LEVEL_MAX);
        sel_ctl_next.neg    = 1'b0;
        if (pixel_in <= in_knee_low_reg)
        begin
            // low segment, 0..out_knee_low
            sel_a_next        = pixel_in;
            sel_b_next        = out_knee_low_reg;
            sel_ctl_next.den  = in_knee_low_reg;
            sel_ctl_next.base = '0;
        end
        else if (pixel_in >= in_knee_high_reg)
        begin
            // high segment, out_knee_high..255
            sel_a_next        = pixel_in - in_knee_high_reg;
            sel_b_next        = LEVEL_MAX - out_knee_high_reg;
            sel_ctl_next.den  = LEVEL_MAX - in_knee_high_reg;
            sel_ctl_next.base = out_knee_high_reg;
        end
        else
        begin
            // middle segment, slope may fall
            sel_a_next        = pixel_in - in_knee_low_reg;
            sel_ctl_next.den  = in_knee_high_reg - in_knee_low_reg;
            sel_ctl_next.base = out_knee_low_reg;
            if (out_knee_high_reg >= out_knee_low_reg)
            begin
                sel_b_next = out_knee_high_reg - out_knee_low_reg;
            end
            else
            begin
                sel_b_next       = out_knee_low_reg - out_knee_high_reg;
                sel_ctl_next.neg = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sel_ctl_reg <= sel_ctl_next;
            sel_a_reg   <= sel_a_next;
            sel_b_reg   <= sel_b_next;
        end
    end

    // multiply; quotient always fits 8 bits so the top byte starts below den
    assign prod = num_t'(sel_a_reg) * num_t'(sel_b_reg);

    always_comb
    begin
        div_init.ctl = sel_ctl_reg;
        div_init.rem = prod[NUM_W-1:PIX_W];
        div_init.low = prod[PIX_W-1:0];
        div_init.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            div_reg[0] <= div_init;
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (adv[k+2])
            begin
                div_reg[k+1] <= div_stage(div_reg[k]);
            end
        end
    end

    // offset; a falling slope floors toward minus infinity
    always_comb
    begin
        if (div_reg[DIV_STAGES].ctl.bypass)
        begin
            result_next = div_reg[DIV_STAGES].ctl.pix;
        end
        else if (div_reg[DIV_STAGES].ctl.neg)
        begin
            result_next = div_reg[DIV_STAGES].ctl.base - div_reg[DIV_STAGES].quo
                          - pix_t'(div_reg[DIV_STAGES].rem != '0);
        end
        else
        begin
            result_next = div_reg[DIV_STAGES].ctl.base + div_reg[DIV_STAGES].quo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            result_reg <= result_next;
        end
    end

endmodule
